FILE: design/text_terminal_cursor_engine_unit_macros.svh
// Assertion macros for the text terminal cursor engine checker.
// No dependencies; included by the checker file only.
`ifndef TEXT_TERMINAL_CURSOR_ENGINE_UNIT_MACROS_SVH
`define TEXT_TERMINAL_CURSOR_ENGINE_UNIT_MACROS_SVH

// Clocked assertion, disabled while the given reset is asserted (active low).
`define TTCE_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the standard clk and rst_n names of this block.
`define TTCE_ASSERT(lbl, prop, msg) \
  `TTCE_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

FILE: design/ttce_pkg.sv
// Shared types and constants for the text terminal cursor engine.
// Used by the controller, the datapath, the top level and the checker.
package ttce_pkg;

  // Default screen geometry.
  localparam int COLS_DEF = 64;
  localparam int ROWS_DEF = 32;

  // Fixed field widths.
  localparam int IDX_W  = 11;
  localparam int DATA_W = 8;
  localparam int BW_W   = 4;

  // Character codes.
  localparam logic [DATA_W-1:0] CH_BS    = 8'd8;
  localparam logic [DATA_W-1:0] CH_CR    = 8'd13;
  localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CH_TILDE = 8'h7E;

  // Opcodes.
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ_WAIT,
    ST_SCR_RD,
    ST_SCR_WR
  } ttce_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;    // write zero at the sweep pointer, advance it
    logic load;      // capture the input word
    logic exec;      // carry out a character word
    logic rd_issue;  // read the screen at the requested address
    logic scr_rd;    // read the cell one row below the sweep pointer
    logic scr_wr;    // write the read cell at the sweep pointer, advance it
    logic zero_wr;   // zero the bottom inner row cell at the pointer, advance it
    logic emit;      // register the result word
  } ttce_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic scroll;
    logic ptr_copy;
    logic ptr_last_scr;
    logic ptr_last_clr;
  } ttce_status_t;

endpackage

FILE: design/text_terminal_cursor_engine_unit.sv
// Top level of the text terminal cursor engine.
// Depends on ttce_pkg, ttce_ctrl and ttce_datapath.
//
//  Channel  Handshake            Payload
//  -------  -------------------  ----------------------------------------------
//  input    start && !busy       in_opcode, in_char_code, in_read_address
//  result   out_strobe (1 cycle) out_read_data, out_cursor_index, out_scrolled
//  config   cfg_we               cfg_border_width
//
// A character word without scroll is carried out in DECODE, where its result
// is registered for the strobe; a read issues its memory read in DECODE and
// emits its result from READ_WAIT. A scroll walks the single-port screen
// memory, copying the moved rows cell by cell and zeroing the bottom inner row.
// After reset the memory is cleared one cell a cycle with busy high; config
// writes are taken during that time. Results cannot stall.
module text_terminal_cursor_engine_unit #(
  parameter int COLS = ttce_pkg::COLS_DEF,
  parameter int ROWS = ttce_pkg::ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_opcode,
  input  logic [ttce_pkg::DATA_W-1:0] in_char_code,
  input  logic [ttce_pkg::IDX_W-1:0]  in_read_address,
  output logic                        out_strobe,
  output logic [ttce_pkg::DATA_W-1:0] out_read_data,
  output logic [ttce_pkg::IDX_W-1:0]  out_cursor_index,
  output logic                        out_scrolled,
  input  logic                        cfg_we,
  input  logic [ttce_pkg::BW_W-1:0]   cfg_border_width
);

  ttce_pkg::ttce_cmd_t    cmd;
  ttce_pkg::ttce_status_t status;

  // Sequencing.
  ttce_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Screen memory, cursor and result registers.
  ttce_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_border_width (cfg_border_width),
    .in_opcode        (in_opcode),
    .in_char_code     (in_char_code),
    .in_read_address  (in_read_address),
    .cmd              (cmd),
    .status           (status),
    .out_read_data    (out_read_data),
    .out_cursor_index (out_cursor_index),
    .out_scrolled     (out_scrolled),
    .out_strobe       (out_strobe)
  );

endmodule

FILE: design/ttce_ctrl.sv
// Controller state machine of the text terminal cursor engine.
// Depends on ttce_pkg for the state, command and status types.
module ttce_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  ttce_pkg::ttce_status_t status,
  output ttce_pkg::ttce_cmd_t   cmd,
  output logic                  busy
);

  ttce_pkg::ttce_state_t state_r, state_nxt;

  // State register; reset starts the screen clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttce_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ttce_pkg::ST_CLEAR: begin
        if (status.ptr_last_clr) state_nxt = ttce_pkg::ST_IDLE;
      end
      ttce_pkg::ST_IDLE: begin
        if (start) state_nxt = ttce_pkg::ST_DECODE;
      end
      ttce_pkg::ST_DECODE: begin
        if (status.is_read) begin
          state_nxt = ttce_pkg::ST_READ_WAIT;
        end else if (status.scroll) begin
          state_nxt = ttce_pkg::ST_SCR_RD;
        end else begin
          state_nxt = ttce_pkg::ST_IDLE;
        end
      end
      ttce_pkg::ST_READ_WAIT: begin
        state_nxt = ttce_pkg::ST_IDLE;
      end
      ttce_pkg::ST_SCR_RD: begin
        if (status.ptr_copy) begin
          state_nxt = ttce_pkg::ST_SCR_WR;
        end else if (status.ptr_last_scr) begin
          state_nxt = ttce_pkg::ST_IDLE;
        end
      end
      ttce_pkg::ST_SCR_WR: begin
        state_nxt = ttce_pkg::ST_SCR_RD;
      end
      default: begin
        state_nxt = ttce_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands for the datapath.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ttce_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      ttce_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ttce_pkg::ST_DECODE: begin
        if (status.is_read) begin
          cmd.rd_issue = 1'b1;
        end else begin
          cmd.exec = 1'b1;
          cmd.emit = !status.scroll;
        end
      end
      ttce_pkg::ST_READ_WAIT: begin
        cmd.emit = 1'b1;
      end
      ttce_pkg::ST_SCR_RD: begin
        if (status.ptr_copy) begin
          cmd.scr_rd = 1'b1;
        end else begin
          cmd.zero_wr = 1'b1;
          cmd.emit    = status.ptr_last_scr;
        end
      end
      ttce_pkg::ST_SCR_WR: begin
        cmd.scr_wr = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: design/ttce_datapath.sv
// Datapath of the text terminal cursor engine: screen memory, cursor,
// border register, sweep pointer and result registers. Depends on ttce_pkg.
module ttce_datapath #(
  parameter int COLS = ttce_pkg::COLS_DEF,
  parameter int ROWS = ttce_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ttce_pkg::BW_W-1:0]     cfg_border_width,
  input  logic                          in_opcode,
  input  logic [ttce_pkg::DATA_W-1:0]   in_char_code,
  input  logic [ttce_pkg::IDX_W-1:0]    in_read_address,
  input  ttce_pkg::ttce_cmd_t           cmd,
  output ttce_pkg::ttce_status_t        status,
  output logic [ttce_pkg::DATA_W-1:0]   out_read_data,
  output logic [ttce_pkg::IDX_W-1:0]    out_cursor_index,
  output logic                          out_scrolled,
  output logic                          out_strobe
);

  localparam int CELLS  = COLS * ROWS;
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int AX_W   = ((ADDR_W > ttce_pkg::IDX_W) ? ADDR_W : ttce_pkg::IDX_W) + 1;
  localparam int SUM_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + 5;
  localparam int EMAX   = (((COLS < ROWS) ? COLS : ROWS) - 1) / 2;

  localparam logic [ttce_pkg::DATA_W-1:0] ZERO_BYTE = '0;

  // Registers.
  logic [ttce_pkg::BW_W-1:0]   border_r;
  logic [ROW_W-1:0]            row_r, row_nxt;
  logic [COL_W-1:0]            col_r, col_nxt;
  logic [ADDR_W-1:0]           ptr_r, ptr_nxt;
  logic                        op_r;
  logic [ttce_pkg::DATA_W-1:0] ch_r;
  logic [ttce_pkg::IDX_W-1:0]  addr_r;
  logic                        scroll_r;
  logic [ttce_pkg::DATA_W-1:0] rdata_r;
  logic [ttce_pkg::DATA_W-1:0] mem_r [CELLS];
  logic [ttce_pkg::DATA_W-1:0] out_read_data_r;
  logic [ttce_pkg::IDX_W-1:0]  out_cursor_index_r;
  logic                        out_scrolled_r;
  logic                        out_strobe_r;

  // Derived values.
  logic [SUM_W-1:0]            eff_e, cfg_e, last_inner, row_x, col_x;
  logic [AX_W-1:0]             cur_addr, scr_start, zero_base, scr_end, ptr_x, addr_x;
  logic [AX_W-1:0]             cursor_nxt_x;
  logic                        is_print, wrap, lf, lf_scroll, bs_ok, addr_ok, scroll;
  logic                        we;
  logic [ADDR_W-1:0]           waddr, raddr;
  logic [ttce_pkg::DATA_W-1:0] wdata;

  // Effective border and the geometry of the inner area.
  always_comb begin
    eff_e = (SUM_W'(border_r) < SUM_W'(EMAX)) ? SUM_W'(border_r) : SUM_W'(EMAX);
    cfg_e = (SUM_W'(cfg_border_width) < SUM_W'(EMAX)) ?
            SUM_W'(cfg_border_width) : SUM_W'(EMAX);
    last_inner = SUM_W'(ROWS) - eff_e - SUM_W'(1);
    row_x      = SUM_W'(row_r);
    col_x      = SUM_W'(col_r);
    cur_addr   = AX_W'(row_r) * AX_W'(COLS) + AX_W'(col_r);
    scr_start  = AX_W'(eff_e) * AX_W'(COLS);
    zero_base  = AX_W'(last_inner) * AX_W'(COLS);
    scr_end    = zero_base + AX_W'(COLS - 1);
    ptr_x      = AX_W'(ptr_r);
    addr_x     = AX_W'(addr_r);
    addr_ok    = addr_x < AX_W'(CELLS);
  end

  // Classification of the latched character word.
  always_comb begin
    is_print  = (ch_r >= ttce_pkg::CH_SPACE) && (ch_r <= ttce_pkg::CH_TILDE);
    wrap      = (col_x + SUM_W'(1) + eff_e) >= SUM_W'(COLS);
    lf        = (is_print && wrap) || (ch_r == ttce_pkg::CH_CR);
    lf_scroll = row_x >= last_inner;
    bs_ok     = (ch_r == ttce_pkg::CH_BS) && (col_x > eff_e + SUM_W'(1));
    scroll    = (op_r == ttce_pkg::OP_CHAR) && lf && lf_scroll;
  end

  // Status for the controller.
  always_comb begin
    status.is_read      = (op_r == ttce_pkg::OP_READ);
    status.scroll       = scroll;
    status.ptr_copy     = ptr_x < zero_base;
    status.ptr_last_scr = ptr_x == scr_end;
    status.ptr_last_clr = ptr_x == AX_W'(CELLS - 1);
  end

  // Cursor and sweep pointer updates; a register write moves the cursor home.
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    ptr_nxt = ptr_r;
    if (cmd.exec && (op_r == ttce_pkg::OP_CHAR)) begin
      if (lf) begin
        col_nxt = COL_W'(eff_e);
        if (lf_scroll) begin
          row_nxt = (row_x > last_inner) ? ROW_W'(last_inner) : row_r;
          ptr_nxt = ADDR_W'(scr_start);
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else if (is_print) begin
        col_nxt = col_r + COL_W'(1);
      end else if (bs_ok) begin
        col_nxt = col_r - COL_W'(1);
      end
    end
    if (cmd.clr_wr || cmd.scr_wr || cmd.zero_wr) begin
      ptr_nxt = ptr_r + ADDR_W'(1);
    end
    if (cfg_we) begin
      row_nxt = ROW_W'(cfg_e);
      col_nxt = COL_W'(cfg_e);
    end
    cursor_nxt_x = AX_W'(row_nxt) * AX_W'(COLS) + AX_W'(col_nxt);
  end

  // Memory write and read port selection.
  always_comb begin
    we    = 1'b0;
    waddr = ptr_r;
    wdata = ZERO_BYTE;
    if (cmd.clr_wr || cmd.zero_wr) begin
      we = 1'b1;
    end else if (cmd.scr_wr) begin
      we    = 1'b1;
      wdata = rdata_r;
    end else if (cmd.exec && (op_r == ttce_pkg::OP_CHAR)) begin
      if (is_print) begin
        we    = 1'b1;
        waddr = ADDR_W'(cur_addr);
        wdata = ch_r;
      end else if (bs_ok) begin
        we    = 1'b1;
        waddr = ADDR_W'(cur_addr - AX_W'(1));
        wdata = ttce_pkg::CH_SPACE;
      end
    end
    raddr = cmd.scr_rd ? ADDR_W'(ptr_x + AX_W'(COLS)) : ADDR_W'(addr_x);
  end

  // Screen memory with registered read; the read data holds between requests.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (cmd.rd_issue || cmd.scr_rd) begin
      rdata_r <= mem_r[raddr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      border_r     <= '0;
      row_r        <= '0;
      col_r        <= '0;
      ptr_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        border_r <= cfg_border_width;
      end
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      ptr_r        <= ptr_nxt;
      out_strobe_r <= cmd.emit;
    end
  end

  // Latched input word and scroll flag.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_opcode;
      ch_r     <= in_char_code;
      addr_r   <= in_read_address;
      scroll_r <= 1'b0;
    end else if (cmd.exec) begin
      scroll_r <= scroll;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_read_data_r    <= ((op_r == ttce_pkg::OP_READ) && addr_ok) ? rdata_r : ZERO_BYTE;
      out_cursor_index_r <= cursor_nxt_x[ttce_pkg::IDX_W-1:0];
      out_scrolled_r     <= scroll_r;
    end
  end

  assign out_read_data    = out_read_data_r;
  assign out_cursor_index = out_cursor_index_r;
  assign out_scrolled     = out_scrolled_r;
  assign out_strobe       = out_strobe_r;

endmodule

FILE: design/ttce_checker.sv
// Port-level checker for the text terminal cursor engine, bound to the top.
// Depends on ttce_pkg and the assertion macros header.
`include "text_terminal_cursor_engine_unit_macros.svh"

module ttce_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_strobe,
  input logic [ttce_pkg::DATA_W-1:0] out_read_data,
  input logic                        out_scrolled
);

  // An accepted word makes the block busy in the next cycle.
  `TTCE_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")

  // A result is only delivered once the block has finished with its word.
  `TTCE_ASSERT(a_strobe_idle, out_strobe |-> !busy, "result strobe while busy")

  // Each word yields one result: the strobe is a pulse and is never held high.
  `TTCE_ASSERT(a_strobe_pulse, out_strobe |=> !out_strobe, "result strobe held")

  // A read that returns data never scrolls.
  `TTCE_ASSERT(a_read_no_scroll, (out_strobe && (out_read_data != '0)) |-> !out_scrolled, "read reported scroll")

endmodule

bind text_terminal_cursor_engine_unit ttce_checker u_ttce_checker (.*);

FILE: tb/sv/text_terminal_cursor_engine_unit_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the text terminal cursor engine: follows the word, result and border ports,
// keeps a shadow screen and cursor, and compares every result word field by field.
// Depends on ttce_pkg for field widths, opcodes and character codes.
module text_terminal_cursor_engine_unit_checker
  import ttce_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic              in_opcode,
  input  logic [DATA_W-1:0] in_char_code,
  input  logic [IDX_W-1:0]  in_read_address,
  input  logic              out_strobe,
  input  logic [DATA_W-1:0] out_read_data,
  input  logic [IDX_W-1:0]  out_cursor_index,
  input  logic              out_scrolled,
  input  logic              cfg_we,
  input  logic [BW_W-1:0]   cfg_border_width,
  output int unsigned       fail_count,
  output int unsigned       words_in_flight
);

  localparam int CELLS      = COLS * ROWS;
  localparam int MIN_DIM    = (COLS < ROWS) ? COLS : ROWS;
  localparam int BORDER_CAP = (MIN_DIM - 1) / 2;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [IDX_W-1:0]  cursor_index;
    logic              scrolled;
  } term_word_t;

  logic [DATA_W-1:0] shadow_screen [CELLS];
  int unsigned       shadow_cursor;
  logic [BW_W-1:0]   shadow_border;
  term_word_t        expected_words [$];
  int unsigned       mismatches = 0;

  assign fail_count = mismatches;

  // The border in use, limited so that at least one inner cell remains.
  function automatic int unsigned inner_border();
    int unsigned b;
    b = shadow_border;
    return (b < BORDER_CAP) ? b : BORDER_CAP;
  endfunction

  // Move the cursor to the next inner line, scrolling the inner rows when it runs off the bottom.
  task automatic next_line(input int unsigned row, output logic scrolled);
    int unsigned e, last_inner, moved, i;
    e = inner_border();
    last_inner = ROWS - e - 1;
    if (row + 1 > last_inner) begin
      moved = ROWS - 2 * e - 1;
      for (i = e * COLS; i < (e + moved) * COLS; i++) begin
        shadow_screen[i] = shadow_screen[i + COLS];
      end
      for (i = 0; i < COLS; i++) begin
        shadow_screen[last_inner * COLS + i] = '0;
      end
      if (row > last_inner) begin
        row = last_inner;
      end
      shadow_cursor = row * COLS + e;
      scrolled = 1'b1;
    end else begin
      shadow_cursor = (row + 1) * COLS + e;
      scrolled = 1'b0;
    end
  endtask

  // Carry one input word through the shadow state and return the result word it should give.
  task automatic apply_word(input logic op, input logic [DATA_W-1:0] ch,
                            input logic [IDX_W-1:0] addr, output term_word_t res);
    int unsigned e, col, row;
    logic scr;
    e = inner_border();
    scr = 1'b0;
    res = '0;
    if (shadow_cursor >= CELLS) begin
      shadow_cursor = e * (COLS + 1);
    end
    if (op == OP_READ) begin
      if (addr < CELLS) begin
        res.read_data = shadow_screen[addr];
      end
    end else if (ch >= CH_SPACE && ch <= CH_TILDE) begin
      col = shadow_cursor % COLS;
      row = shadow_cursor / COLS;
      shadow_screen[shadow_cursor] = ch;
      if (col + 1 + e >= COLS) begin
        next_line(row, scr);
      end else begin
        shadow_cursor++;
      end
    end else if (ch == CH_CR) begin
      next_line(shadow_cursor / COLS, scr);
    end else if (ch == CH_BS) begin
      // Backspace stops short of the prompt column.
      if (shadow_cursor % COLS > e + 1) begin
        shadow_cursor--;
        shadow_screen[shadow_cursor] = CH_SPACE;
      end
    end
    res.cursor_index = IDX_W'(shadow_cursor);
    res.scrolled = scr;
  endtask

  task automatic note_mismatch(input string field, input int unsigned want, input int unsigned got);
    mismatches++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  // Predict on accepted words and border writes, then check any result word on this edge.
  always @(posedge clk) begin
    term_word_t want;
    int unsigned i;
    if (!rst_n) begin
      for (i = 0; i < CELLS; i++) begin
        shadow_screen[i] = '0;
      end
      shadow_border = '0;
      shadow_cursor = 0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        shadow_border = cfg_border_width;
        shadow_cursor = inner_border() * (COLS + 1);
      end
      if (start && !busy) begin
        apply_word(in_opcode, in_char_code, in_read_address, want);
        expected_words.push_back(want);
      end
      if (out_strobe) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $error("result word with none expected: read_data %0d cursor_index %0d scrolled %0d",
                 out_read_data, out_cursor_index, out_scrolled);
        end else begin
          want = expected_words.pop_front();
          if (out_read_data !== want.read_data) begin
            note_mismatch("read_data", want.read_data, out_read_data);
          end
          if (out_cursor_index !== want.cursor_index) begin
            note_mismatch("cursor_index", want.cursor_index, out_cursor_index);
          end
          if (out_scrolled !== want.scrolled) begin
            note_mismatch("scrolled", want.scrolled, out_scrolled);
          end
        end
      end
    end
    words_in_flight <= expected_words.size();
  end

endmodule

FILE: tb/sv/text_terminal_cursor_engine_unit_test.sv
`timescale 1ns / 100ps
// Top of the terminal cursor engine testbench: clock, reset, word and border stimulus,
// a stall watchdog and the verdict. Depends on ttce_pkg, the engine and its scoreboard.
module text_terminal_cursor_engine_unit_test;
  import ttce_pkg::*;

  localparam int COLS         = COLS_DEF;
  localparam int ROWS         = ROWS_DEF;
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 2 * COLS;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_opcode;
  logic [DATA_W-1:0] in_char_code;
  logic [IDX_W-1:0]  in_read_address;
  logic              out_strobe;
  logic [DATA_W-1:0] out_read_data;
  logic [IDX_W-1:0]  out_cursor_index;
  logic              out_scrolled;
  logic              cfg_we;
  logic [BW_W-1:0]   cfg_border_width;

  int unsigned      fail_count;
  int unsigned      words_in_flight;
  int unsigned      idle_cycles = 0;
  int unsigned      phase_words = 0;
  logic [IDX_W-1:0] last_cursor = '0;

  text_terminal_cursor_engine_unit #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_char_code     (in_char_code),
    .in_read_address  (in_read_address),
    .out_strobe       (out_strobe),
    .out_read_data    (out_read_data),
    .out_cursor_index (out_cursor_index),
    .out_scrolled     (out_scrolled),
    .cfg_we           (cfg_we),
    .cfg_border_width (cfg_border_width)
  );

  text_terminal_cursor_engine_unit_checker #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) screen_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_char_code     (in_char_code),
    .in_read_address  (in_read_address),
    .out_strobe       (out_strobe),
    .out_read_data    (out_read_data),
    .out_cursor_index (out_cursor_index),
    .out_scrolled     (out_scrolled),
    .cfg_we           (cfg_we),
    .cfg_border_width (cfg_border_width),
    .fail_count       (fail_count),
    .words_in_flight  (words_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall watchdog: any accepted word or result word restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reads are aimed near the latest cursor half of the time so that they hit written text.
  always @(posedge clk) begin
    if (out_strobe) begin
      last_cursor <= out_cursor_index;
    end
  end

  // Present one word after the given number of idle cycles and hold it until accepted.
  task automatic send_word(input logic op, input logic [DATA_W-1:0] ch,
                           input logic [IDX_W-1:0] addr, input int unsigned gap);
    logic taken;
    @(negedge clk);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_opcode = op;
    in_char_code = ch;
    in_read_address = addr;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    phase_words++;
  endtask

  // Stop sending and wait until every expected result word has come back.
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    wait (words_in_flight == 0);
    wait (!busy);
  endtask

  task automatic write_border(input logic [BW_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_border_width = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly back to back, sometimes a few cycles, rarely a long pause.
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [DATA_W-1:0] printable();
    return DATA_W'($urandom_range(32'h20, 32'h7E));
  endfunction

  function automatic logic [IDX_W-1:0] any_address();
    return IDX_W'($urandom);
  endfunction

  function automatic logic [IDX_W-1:0] read_target();
    if ($urandom_range(0, 1) == 0) begin
      return any_address();
    end
    return last_cursor - IDX_W'($urandom_range(0, 2 * COLS));
  endfunction

  // Random traffic in bursts: text lines, blank lines, backspaces, reads and stray bytes.
  task automatic run_phase(input int unsigned budget);
    int unsigned kind, len, k;
    bit steady;
    phase_words = 0;
    while (phase_words < budget) begin
      kind = $urandom_range(0, 99);
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 49) == 0) begin
        settle();
      end
      if (kind < 40) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 140) : $urandom_range(0, 8);
        for (k = 0; k < len; k++) begin
          send_word(OP_CHAR, printable(), any_address(), pick_gap(steady));
        end
        if ($urandom_range(0, 9) < 7) begin
          send_word(OP_CHAR, CH_CR, any_address(), pick_gap(steady));
        end
      end else if (kind < 60) begin
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          send_word(OP_CHAR, CH_CR, any_address(), pick_gap(steady));
        end
      end else if (kind < 70) begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
          send_word(OP_CHAR, CH_BS, any_address(), pick_gap(steady));
        end
      end else if (kind < 90) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
          send_word(OP_READ, DATA_W'($urandom), read_target(), pick_gap(steady));
        end
      end else begin
        len = $urandom_range(1, 3);
        for (k = 0; k < len; k++) begin
          send_word(1'($urandom), DATA_W'($urandom), any_address(), pick_gap(steady));
        end
      end
    end
  endtask

  initial begin
    start = 1'b0;
    in_opcode = OP_CHAR;
    in_char_code = '0;
    in_read_address = '0;
    cfg_we = 1'b0;
    cfg_border_width = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset border: reads at both address extremes, printable limits, ignored bytes.
    send_word(OP_READ, 8'hFF, '0, 0);
    send_word(OP_READ, 8'h00, '1, 1);
    send_word(OP_CHAR, CH_BS, '0, 0);
    send_word(OP_CHAR, CH_SPACE, '1, 0);
    send_word(OP_CHAR, CH_TILDE, '0, 2);
    send_word(OP_CHAR, 8'h1F, '0, 0);
    send_word(OP_CHAR, 8'h7F, '0, 0);
    send_word(OP_CHAR, 8'hFF, '1, 0);
    send_word(OP_CHAR, 8'h00, '0, 3);
    send_word(OP_CHAR, 8'h41, '0, 0);
    // Backspaces walk back until the prompt column stops them.
    send_word(OP_CHAR, CH_BS, '0, 0);
    send_word(OP_CHAR, CH_BS, '0, 0);
    send_word(OP_CHAR, CH_BS, '0, 1);
    send_word(OP_READ, 8'h41, 11'd0, 0);
    send_word(OP_READ, 8'h00, 11'd1, 0);
    send_word(OP_READ, 8'h00, 11'd2, 0);
    send_word(OP_CHAR, CH_CR, '0, 0);
    send_word(OP_READ, CH_CR, 11'd1, 0);
    run_phase(400);

    // Widest border: two inner rows, so the second carriage return scrolls at once.
    write_border(4'd15);
    send_word(OP_CHAR, CH_CR, '0, 0);
    send_word(OP_CHAR, CH_CR, '0, 0);
    send_word(OP_CHAR, 8'h5A, '0, 0);
    send_word(OP_READ, 8'h00, IDX_W'(16 * COLS + 15), 0);
    send_word(OP_CHAR, CH_BS, '0, 0);
    send_word(OP_CHAR, 8'h59, '0, 0);
    send_word(OP_CHAR, CH_BS, '0, 0);
    run_phase(150);

    write_border(4'd6);
    run_phase(200);
    write_border(4'd1);
    run_phase(200);
    write_border(4'd14);
    run_phase(150);
    write_border(BW_W'($urandom_range(2, 13)));
    run_phase(150);
    write_border(4'd0);
    run_phase(175);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/ttce_pkg.sv
design/ttce_ctrl.sv
design/ttce_datapath.sv
design/text_terminal_cursor_engine_unit.sv
design/ttce_checker.sv
tb/sv/text_terminal_cursor_engine_unit_checker.sv
tb/sv/text_terminal_cursor_engine_unit_test.sv
